// File: rtl/core/dtls_pkg.sv
// Package for the density traffic light sequencer: request types, register
// indexes, phase codes, reset values and the lamp and segment tables.
// No dependencies.
package dtls_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned TICK_W     = 4;
  localparam int unsigned TOTAL_W    = 5;

  localparam logic [CFG_ADDR_W-1:0] REG_YELLOW_TIME = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_EMPTY = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_ONE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_TWO   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_FULL  = 3'd4;

  localparam logic [TICK_W-1:0] RST_YELLOW_TIME = 4'd2;
  localparam logic [TICK_W-1:0] RST_GREEN_EMPTY = 4'd3;
  localparam logic [TICK_W-1:0] RST_GREEN_ONE   = 4'd5;
  localparam logic [TICK_W-1:0] RST_GREEN_TWO   = 4'd7;
  localparam logic [TICK_W-1:0] RST_GREEN_FULL  = 4'd9;

  localparam logic [1:0] PH_VERT_GREEN   = 2'd0;
  localparam logic [1:0] PH_VERT_YELLOW  = 2'd1;
  localparam logic [1:0] PH_HORIZ_GREEN  = 2'd2;
  localparam logic [1:0] PH_HORIZ_YELLOW = 2'd3;

  localparam logic [2:0] SENS_EMPTY = 3'b111;
  localparam logic [2:0] SENS_ONE   = 3'b110;
  localparam logic [2:0] SENS_TWO   = 3'b100;
  localparam logic [2:0] SENS_FULL  = 3'b000;

  localparam logic [7:0] SEG_BLANK = 8'hff;
  localparam logic [TOTAL_W-1:0] DIGIT_MAX = 5'd9;

  typedef struct packed {
    logic [2:0] horiz_sensors;
    logic [2:0] vert_sensors;
  } in_req_t;

  typedef struct packed {
    logic [5:0] lamps;
    logic [7:0] first_digit;
    logic [7:0] second_digit;
    logic [1:0] phase;
  } out_req_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'h3f;
      4'd1: code = 8'h06;
      4'd2: code = 8'h5b;
      4'd3: code = 8'h4f;
      4'd4: code = 8'h66;
      4'd5: code = 8'h6d;
      4'd6: code = 8'h7d;
      4'd7: code = 8'h07;
      4'd8: code = 8'h7f;
      4'd9: code = 8'hef;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [5:0] lamp_pattern(input logic [1:0] ph);
    logic [5:0] lamps;
    case (ph)
      PH_VERT_GREEN:   lamps = 6'h33;
      PH_VERT_YELLOW:  lamps = 6'h35;
      PH_HORIZ_GREEN:  lamps = 6'h1e;
      PH_HORIZ_YELLOW: lamps = 6'h2e;
      default:         lamps = 6'h33;
    endcase
    return lamps;
  endfunction

endpackage

// File: rtl/core/density_traffic_light_sequencer.sv
// Top level of the density traffic light sequencer: phase counters, sensor
// sampling, digit latches and the result register. Uses dtls_pkg.
// A result is registered in the output register when its request is accepted.
// Throughput: one request per cycle while out_ready is high; the output register frees itself as it is read.
// Reset (synchronous, rst_n low) restores the register defaults, the phase
// state, the green times and blank digit latches, and empties the output.
module density_traffic_light_sequencer
  import dtls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_req_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TICK_W-1:0]  yellow_time_r, green_empty_r, green_one_r, green_two_r, green_full_r;
  logic [1:0]         phase_r, phase_nxt;
  logic               start_r, start_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TICK_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0]  horiz_green_r, horiz_green_nxt;
  logic [TICK_W-1:0]  vert_green_r, vert_green_nxt;
  logic [7:0]         first_latch_r, first_latch_nxt;
  logic [7:0]         second_latch_r, second_latch_nxt;
  logic               out_valid_r;
  out_req_t           out_data_r, out_data_nxt;

  logic               accept;
  logic [TICK_W-1:0]  yellow_eff, green_sel, green_eff, count_cur;
  logic [TOTAL_W-1:0] total_cur, first_val, second_val;

  function automatic logic [TICK_W-1:0] depth_to_green(input logic [2:0] pins,
                                                       input logic [TICK_W-1:0] prev,
                                                       input logic [TICK_W-1:0] g_empty,
                                                       input logic [TICK_W-1:0] g_one,
                                                       input logic [TICK_W-1:0] g_two,
                                                       input logic [TICK_W-1:0] g_full);
    logic [TICK_W-1:0] g;
    case (pins)
      SENS_EMPTY: g = g_empty;
      SENS_ONE:   g = g_one;
      SENS_TWO:   g = g_two;
      SENS_FULL:  g = g_full;
      default:    g = prev;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] latch_digit(input logic [7:0] latch,
                                             input logic [TOTAL_W-1:0] value);
    logic [7:0] res;
    res = latch;
    if (value <= DIGIT_MAX) begin
      res = SEG_BLANK - seg_code(value[3:0]);
    end
    return res;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    horiz_green_nxt = horiz_green_r;
    vert_green_nxt  = vert_green_r;
    count_cur       = count_r;
    total_cur       = total_r;
    yellow_eff      = (yellow_time_r == '0) ? TICK_W'(1) : yellow_time_r;
    green_sel       = '0;
    green_eff       = '0;
    if (start_r) begin
      if (!phase_r[0]) begin
        horiz_green_nxt = depth_to_green(in_data.horiz_sensors, horiz_green_r, green_empty_r,
                                         green_one_r, green_two_r, green_full_r);
        vert_green_nxt  = depth_to_green(in_data.vert_sensors, vert_green_r, green_empty_r,
                                         green_one_r, green_two_r, green_full_r);
        green_sel = (phase_r == PH_VERT_GREEN) ? vert_green_nxt : horiz_green_nxt;
        green_eff = (green_sel == '0) ? TICK_W'(1) : green_sel;
        count_cur = green_eff;
        total_cur = TOTAL_W'(green_eff) + TOTAL_W'(yellow_eff);
      end else begin
        count_cur = yellow_eff;
      end
    end

    if (phase_r < PH_HORIZ_GREEN) begin
      first_val  = total_cur;
      second_val = TOTAL_W'(count_cur);
    end else begin
      first_val  = TOTAL_W'(count_cur);
      second_val = total_cur;
    end
    first_latch_nxt  = latch_digit(first_latch_r, first_val);
    second_latch_nxt = latch_digit(second_latch_r, second_val);

    out_data_nxt.lamps        = lamp_pattern(phase_r);
    out_data_nxt.first_digit  = first_latch_nxt;
    out_data_nxt.second_digit = second_latch_nxt;
    out_data_nxt.phase        = phase_r;

    count_nxt = (count_cur == '0) ? '0 : count_cur - TICK_W'(1);
    total_nxt = (total_cur == '0) ? '0 : total_cur - TOTAL_W'(1);
    if (count_nxt == '0) begin
      phase_nxt = phase_r + 2'd1;
      start_nxt = 1'b1;
    end else begin
      phase_nxt = phase_r;
      start_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yellow_time_r <= RST_YELLOW_TIME;
      green_empty_r <= RST_GREEN_EMPTY;
      green_one_r   <= RST_GREEN_ONE;
      green_two_r   <= RST_GREEN_TWO;
      green_full_r  <= RST_GREEN_FULL;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_YELLOW_TIME: yellow_time_r <= cfg_wdata;
        REG_GREEN_EMPTY: green_empty_r <= cfg_wdata;
        REG_GREEN_ONE:   green_one_r   <= cfg_wdata;
        REG_GREEN_TWO:   green_two_r   <= cfg_wdata;
        REG_GREEN_FULL:  green_full_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_VERT_GREEN;
      start_r        <= 1'b1;
      total_r        <= '0;
      count_r        <= '0;
      horiz_green_r  <= RST_GREEN_EMPTY;
      vert_green_r   <= RST_GREEN_EMPTY;
      first_latch_r  <= SEG_BLANK;
      second_latch_r <= SEG_BLANK;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        phase_r        <= phase_nxt;
        start_r        <= start_nxt;
        total_r        <= total_nxt;
        count_r        <= count_nxt;
        horiz_green_r  <= horiz_green_nxt;
        vert_green_r   <= vert_green_nxt;
        first_latch_r  <= first_latch_nxt;
        second_latch_r <= second_latch_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_start_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> count_r == '0)
    else $error("phase load pending while the phase count is nonzero");

  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !start_r && count_r == TICK_W'(1)
      |=> start_r && phase_r == $past(phase_r) + 2'd1)
    else $error("phase did not advance when its count ran out");

  a_lamps_match_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.lamps == lamp_pattern(out_data_r.phase))
    else $error("lamp pattern does not match the reported phase");

endmodule
